// ===== hdl/swam_pkg.sv =====
// Shared types, codes and helpers for the sliding window anagram matcher.
`default_nettype none
package swam_pkg;

  localparam int MAX_PATTERN_DEFAULT = 64;
  localparam int LETTERS   = 26;
  localparam int LETTER_W  = 5;
  localparam int SYM_W     = 8;
  localparam int ACTION_W  = 2;

  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_PATTERN = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_TEXT    = 2'd2;

  localparam logic [SYM_W-1:0] CHAR_A = 8'h61;
  localparam logic [SYM_W-1:0] CHAR_Z = 8'h7a;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // classified item passed from front to back
  typedef struct packed {
    logic [ACTION_W-1:0] op;
    logic [SYM_W-1:0]    symbol;
    logic                is_letter;
    logic [LETTER_W-1:0] letter;
  } swam_op_t;

  function automatic logic is_lower(input logic [SYM_W-1:0] s);
    return (s >= CHAR_A) && (s <= CHAR_Z);
  endfunction

  function automatic logic [LETTER_W-1:0] letter_idx(input logic [SYM_W-1:0] s);
    logic [SYM_W-1:0] d;
    d = s - CHAR_A;
    return d[LETTER_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== hdl/swam_ifs.sv =====
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface swam_in_if;
  logic                          valid;
  logic                          ready;
  logic [swam_pkg::ACTION_W-1:0] action;
  logic [swam_pkg::SYM_W-1:0]    symbol;
  modport source (output valid, output action, output symbol, input ready);
  modport sink   (input valid, input action, input symbol, output ready);
endinterface

interface swam_out_if;
  logic valid;
  logic ready;
  logic match;
  logic found;
  modport source (output valid, output match, output found, input ready);
  modport sink   (input valid, input match, input found, output ready);
endinterface
`default_nettype wire

// ===== hdl/swam_front.sv =====
// Front end: accepts input items, decodes the letter and drops unused action codes.
`default_nettype none
module swam_front (
  swam_in_if.sink           item_in,
  output logic              push_valid,
  input  logic              push_ready,
  output swam_pkg::swam_op_t push_data
);

  logic known_action;

  assign known_action = (item_in.action == swam_pkg::ACT_CLEAR) ||
                        (item_in.action == swam_pkg::ACT_PATTERN) ||
                        (item_in.action == swam_pkg::ACT_TEXT);

  // unused codes are taken and dropped here
  assign item_in.ready = push_ready;
  assign push_valid    = item_in.valid && known_action;

  always_comb begin
    push_data.op        = item_in.action;
    push_data.symbol    = item_in.symbol;
    push_data.is_letter = swam_pkg::is_lower(item_in.symbol);
    push_data.letter    = swam_pkg::letter_idx(item_in.symbol);
  end

endmodule
`default_nettype wire

// ===== hdl/swam_queue.sv =====
// Short FIFO between the front end and the back end.
`default_nettype none
module swam_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push_valid,
  output logic                                push_ready,
  input  swam_pkg::swam_op_t                  push_data,
  output logic                                pop_valid,
  input  logic                                pop_ready,
  output swam_pkg::swam_op_t                  pop_data,
  output logic [swam_pkg::QUEUE_CNT_W-1:0]    count
);

  localparam logic [swam_pkg::QUEUE_IDX_W-1:0] LAST_IDX =
    swam_pkg::QUEUE_IDX_W'(swam_pkg::QUEUE_DEPTH - 1);

  swam_pkg::swam_op_t                  entries [swam_pkg::QUEUE_DEPTH];
  logic [swam_pkg::QUEUE_IDX_W-1:0]    wr_ptr;
  logic [swam_pkg::QUEUE_IDX_W-1:0]    rd_ptr;
  logic                                push;
  logic                                pop;

  assign push_ready = (count != swam_pkg::QUEUE_CNT_W'(swam_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_IDX) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_IDX) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/swam_back.sv =====
// Back end: histograms, window history memory, compare and result register.
`default_nettype none
module swam_back #(
  parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  output logic               q_ready,
  input  swam_pkg::swam_op_t q_data,
  swam_out_if.source         result_out
);

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int PW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic [CW-1:0] pattern_counts [swam_pkg::LETTERS];
  logic [CW-1:0] window_counts  [swam_pkg::LETTERS];
  logic [CW-1:0] window_counts_next [swam_pkg::LETTERS];
  logic [swam_pkg::SYM_W-1:0] window_history [MAX_PATTERN];

  logic [PW-1:0] history_pointer;
  logic [PW-1:0] ptr_inc;
  logic [PW-1:0] rd_addr;
  logic [CW-1:0] pattern_length;
  logic [CW-1:0] text_seen;
  logic [CW-1:0] text_seen_next;
  logic          found_flag;
  logic          text_started;
  logic [swam_pkg::SYM_W-1:0] old_sym;

  logic slot_free;
  logic fire;
  logic do_clear;
  logic do_pattern;
  logic do_text;
  logic advance;
  logic window_full;
  logic evict;
  logic old_is_letter;
  logic [swam_pkg::LETTER_W-1:0] old_letter;
  logic all_equal;
  logic match_next;

  assign slot_free = !result_out.valid || result_out.ready;
  // only text items produce results, so only they wait on the output slot
  assign q_ready   = (q_data.op != swam_pkg::ACT_TEXT) || slot_free;
  assign fire      = q_valid && q_ready;

  assign do_clear   = fire && (q_data.op == swam_pkg::ACT_CLEAR);
  assign do_pattern = fire && (q_data.op == swam_pkg::ACT_PATTERN) && !text_started &&
                      (pattern_length < CW'(MAX_PATTERN));
  assign do_text    = fire && (q_data.op == swam_pkg::ACT_TEXT);

  assign advance     = do_text && (pattern_length != '0);
  assign window_full = (text_seen == pattern_length);
  assign evict       = advance && window_full;

  assign old_is_letter = swam_pkg::is_lower(old_sym);
  assign old_letter    = swam_pkg::letter_idx(old_sym);

  assign text_seen_next = (advance && !window_full) ? text_seen + 1'b1 : text_seen;

  always_comb begin
    for (int i = 0; i < swam_pkg::LETTERS; i++) begin
      window_counts_next[i] = window_counts[i]
        + CW'(advance && q_data.is_letter && (q_data.letter == swam_pkg::LETTER_W'(i)))
        - CW'(evict && old_is_letter && (old_letter == swam_pkg::LETTER_W'(i)) &&
              (window_counts[i] != '0));
    end
  end

  always_comb begin
    all_equal = 1'b1;
    for (int i = 0; i < swam_pkg::LETTERS; i++) begin
      if (pattern_counts[i] != window_counts_next[i]) begin
        all_equal = 1'b0;
      end
    end
  end

  assign match_next = (text_seen_next == pattern_length) && all_equal;

  assign ptr_inc = ((CW'(history_pointer) + 1'b1) == pattern_length) ? '0 :
                   history_pointer + 1'b1;
  assign rd_addr = advance ? ptr_inc : history_pointer;

  // history memory; read data registered, bypassed on a one-entry window
  always_ff @(posedge clk) begin
    if (advance) begin
      window_history[history_pointer] <= q_data.symbol;
    end
    if (advance && (rd_addr == history_pointer)) begin
      old_sym <= q_data.symbol;
    end else begin
      old_sym <= window_history[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      for (int i = 0; i < swam_pkg::LETTERS; i++) begin
        pattern_counts[i] <= '0;
        window_counts[i]  <= '0;
      end
      history_pointer <= '0;
      pattern_length  <= '0;
      text_seen       <= '0;
      found_flag      <= 1'b0;
      text_started    <= 1'b0;
    end else begin
      if (do_pattern) begin
        pattern_length <= pattern_length + 1'b1;
        if (q_data.is_letter) begin
          pattern_counts[q_data.letter] <= pattern_counts[q_data.letter] + 1'b1;
        end
      end
      if (do_text) begin
        text_started <= 1'b1;
        text_seen    <= text_seen_next;
        found_flag   <= found_flag || match_next;
        for (int i = 0; i < swam_pkg::LETTERS; i++) begin
          window_counts[i] <= window_counts_next[i];
        end
      end
      if (advance) begin
        history_pointer <= ptr_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_out.valid <= 1'b0;
    end else if (do_text) begin
      result_out.valid <= 1'b1;
    end else if (result_out.ready) begin
      result_out.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_text) begin
      result_out.match <= match_next;
      result_out.found <= found_flag || match_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sliding_window_anagram_match.sv =====
// Top level of the streaming anagram matcher.
//
//   channel     dir  payload          handshake
//   item_in     in   action, symbol   valid/ready, taken when both high
//   result_out  out  match, found     valid/ready, taken when both high
//
// One item per cycle sustained while results are taken; a text item passes through
// a queue entry, then the result register, before its result is valid.
// The window update and all 26 letter compares are combinational in the back end.
// Reset (rst, synchronous) empties the queue and all histograms; a clear item
// does the same for the back end.
// A stalled result blocks the back end only while a text item is next in the
// queue; items behind it then back up into the queue and the input.
`default_nettype none
module sliding_window_anagram_match #(
  parameter int MAX_PATTERN = swam_pkg::MAX_PATTERN_DEFAULT
) (
  input  wire         clk,
  input  wire         rst,
  swam_in_if.sink     item_in,
  swam_out_if.source  result_out
);

  logic                             push_valid;
  logic                             push_ready;
  swam_pkg::swam_op_t               push_data;
  logic                             pop_valid;
  logic                             pop_ready;
  swam_pkg::swam_op_t               pop_data;
  logic [swam_pkg::QUEUE_CNT_W-1:0] q_count;

  swam_front u_front (
    .item_in    (item_in),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  swam_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .count      (q_count)
  );

  swam_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .q_data     (pop_data),
    .result_out (result_out)
  );

  // a matching window always sets the sticky flag
  a_match_implies_found: assert property (@(posedge clk) disable iff (rst)
    (result_out.valid && result_out.match) |-> result_out.found)
    else $error("match reported without found");

  a_no_result_after_reset: assert property (@(posedge clk)
    rst |=> !result_out.valid)
    else $error("result valid right after reset");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= swam_pkg::QUEUE_CNT_W'(swam_pkg::QUEUE_DEPTH))
    else $error("queue count past depth");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the sliding window anagram matcher: a directed table, then random sequences.
module testbench;
  import swam_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int WINDOW_MAX    = MAX_PATTERN_DEFAULT;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int DRAIN_CYCLES  = 10;
  localparam int PHASE_ITEMS   = 320;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    logic match;
    logic found;
  } verdict_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [SYM_W-1:0]    symbol;
    logic                known;
    verdict_t            verdict;
  } probe_row_t;

  logic clk;
  logic rst;

  swam_in_if  item_in ();
  swam_out_if result_out ();

  sliding_window_anagram_match dut (
    .clk        (clk),
    .rst        (rst),
    .item_in    (item_in),
    .result_out (result_out)
  );

  // letter histograms, window history and flags tracked alongside the block
  int               pat_hist [LETTERS];
  int               win_hist [LETTERS];
  logic [SYM_W-1:0] recent [WINDOW_MAX];
  int               slot;
  int               pat_len;
  int               text_count;
  logic             seen_match;
  logic             text_begun;

  verdict_t pending_verdicts [$];
  int       errors = 0;
  int       cycle_count = 0;
  int       tx_idle_pct = 15;
  int       rx_idle_pct = 88;

  // typed-in verdict travels with the item so the input monitor can pick it up
  logic     row_known;
  verdict_t row_verdict;

  logic [SYM_W-1:0] pat_buf [WINDOW_MAX + 8];

  // verdict = {match, found}
  probe_row_t directed [DIRECTED_ROWS] = '{
    '{ACT_TEXT,    CHAR_A, 1'b1, 2'b11},  // empty pattern matches every byte
    '{ACT_TEXT,    8'hff,  1'b1, 2'b11},
    '{ACT_UNUSED,  8'h00,  1'b0, 2'b00},
    '{ACT_CLEAR,   8'h00,  1'b0, 2'b00},
    '{ACT_PATTERN, CHAR_A, 1'b0, 2'b00},
    '{ACT_PATTERN, 8'h62,  1'b0, 2'b00},
    '{ACT_TEXT,    8'h62,  1'b1, 2'b00},  // window still filling
    '{ACT_TEXT,    CHAR_A, 1'b0, 2'b00},
    '{ACT_PATTERN, CHAR_Z, 1'b0, 2'b00},  // late pattern byte, dropped
    '{ACT_TEXT,    CHAR_Z, 1'b0, 2'b00},
    '{ACT_TEXT,    8'h41,  1'b0, 2'b00},
    '{ACT_TEXT,    8'h62,  1'b0, 2'b00},
    '{ACT_CLEAR,   8'h55,  1'b0, 2'b00},
    '{ACT_PATTERN, 8'h60,  1'b0, 2'b00},  // just below 'a'
    '{ACT_PATTERN, 8'h7b,  1'b0, 2'b00},  // just above 'z'
    '{ACT_TEXT,    8'h00,  1'b1, 2'b00},
    '{ACT_TEXT,    8'hff,  1'b0, 2'b00},
    '{ACT_CLEAR,   8'hff,  1'b0, 2'b00},
    '{ACT_PATTERN, CHAR_Z, 1'b0, 2'b00},
    '{ACT_TEXT,    CHAR_Z, 1'b1, 2'b11},
    '{ACT_TEXT,    CHAR_A, 1'b1, 2'b01},  // found stays set
    '{ACT_UNUSED,  8'hff,  1'b0, 2'b00},
    '{ACT_PATTERN, CHAR_A, 1'b0, 2'b00},
    '{ACT_TEXT,    CHAR_Z, 1'b0, 2'b00},
    '{ACT_CLEAR,   8'haa,  1'b0, 2'b00}
  };

  function automatic int letter_of(input logic [SYM_W-1:0] s);
    if (s >= CHAR_A && s <= CHAR_Z) return int'(s - CHAR_A);
    return -1;
  endfunction

  function automatic void forget_all();
    for (int i = 0; i < LETTERS; i++) begin
      pat_hist[i] = 0;
      win_hist[i] = 0;
    end
    slot       = 0;
    pat_len    = 0;
    text_count = 0;
    seen_match = 1'b0;
    text_begun = 1'b0;
  endfunction

  // Applies one item to the tracked state; returns 1 when the item yields a verdict.
  function automatic bit anagram_step(input logic [ACTION_W-1:0] act,
                                      input logic [SYM_W-1:0] sym,
                                      output verdict_t v);
    int li;
    int oi;
    int p;
    bit same;
    li = letter_of(sym);
    v  = '0;
    case (act)
      ACT_CLEAR: begin
        forget_all();
      end
      ACT_PATTERN: begin
        if (!text_begun && pat_len < WINDOW_MAX) begin
          pat_len++;
          if (li >= 0) pat_hist[li]++;
        end
      end
      ACT_TEXT: begin
        text_begun = 1'b1;
        if (pat_len > 0) begin
          p = (slot >= pat_len) ? 0 : slot;
          if (text_count >= pat_len) begin
            oi = letter_of(recent[p]);
            if (oi >= 0 && win_hist[oi] > 0) win_hist[oi]--;
          end else begin
            text_count++;
          end
          recent[p] = sym;
          if (li >= 0) win_hist[li]++;
          p++;
          slot = (p >= pat_len) ? 0 : p;
        end
        same = (text_count == pat_len);
        for (int i = 0; i < LETTERS; i++)
          if (pat_hist[i] != win_hist[i]) same = 0;
        if (same) seen_match = 1'b1;
        v.match = same;
        v.found = seen_match;
      end
      default: ;
    endcase
    return act == ACT_TEXT;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    result_out.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : input_monitor
    verdict_t v;
    if (rst) begin
      forget_all();
    end else if (item_in.valid && item_in.ready) begin
      if (anagram_step(item_in.action, item_in.symbol, v))
        pending_verdicts.push_back(row_known ? row_verdict : v);
    end
  end

  always @(posedge clk) begin : result_check
    verdict_t want;
    if (!rst && result_out.valid && result_out.ready) begin
      if (pending_verdicts.size() == 0) begin
        $error("unexpected result item: match %0d found %0d",
               result_out.match, result_out.found);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (result_out.match !== want.match) begin
          $error("match: expected %0d, got %0d", want.match, result_out.match);
          errors++;
        end
        if (result_out.found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, result_out.found);
          errors++;
        end
      end
    end
  end

  task automatic push_item(input logic [ACTION_W-1:0] act, input logic [SYM_W-1:0] sym,
                           input logic known = 1'b0, input verdict_t v = '0);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      item_in.valid <= 1'b0;
      @(posedge clk);
    end
    item_in.valid  <= 1'b1;
    item_in.action <= act;
    item_in.symbol <= sym;
    row_known      <= known;
    row_verdict    <= v;
    do @(posedge clk); while (!item_in.ready);
  endtask

  // mostly letters from a narrow band so windows actually hit the pattern
  function automatic logic [SYM_W-1:0] pick_symbol(input int base, input int span);
    if ($urandom_range(0, 99) < 88)
      return CHAR_A + SYM_W'(base + $urandom_range(0, span - 1));
    return SYM_W'($urandom);
  endfunction

  // Each pass: clear, a pattern, then text with shuffled pattern copies and some noise.
  task automatic random_phase(input int target);
    int done;
    int plen;
    int fill;
    int span;
    int base;
    int tlen;
    int emitted;
    int k;
    int j;
    logic [SYM_W-1:0] perm [WINDOW_MAX + 8];
    logic [SYM_W-1:0] t;
    done = 0;
    while (done < target) begin
      push_item(ACT_CLEAR, SYM_W'($urandom));
      done++;
      k = $urandom_range(0, 99);
      if (k < 5) plen = 0;
      else if (k < 12) plen = $urandom_range(WINDOW_MAX - 4, WINDOW_MAX + 6);
      else plen = $urandom_range(1, 8);
      span = $urandom_range(1, 4);
      base = $urandom_range(0, LETTERS - span);
      for (int i = 0; i < plen; i++) begin
        pat_buf[i] = pick_symbol(base, span);
        push_item(ACT_PATTERN, pat_buf[i]);
        done++;
      end
      fill = (plen < WINDOW_MAX) ? plen : WINDOW_MAX;
      tlen = fill + $urandom_range(0, (fill < 10) ? 3 * fill + 6 : 20);
      emitted = 0;
      while (emitted < tlen) begin
        k = $urandom_range(0, 99);
        if (k < 20 && fill > 0) begin
          for (int i = 0; i < fill; i++) perm[i] = pat_buf[i];
          for (int i = fill - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
          end
          for (int i = 0; i < fill; i++) push_item(ACT_TEXT, perm[i]);
          emitted += fill;
          done += fill;
        end else if (k < 23) begin
          push_item(ACT_UNUSED, SYM_W'($urandom));
          done++;
        end else if (k < 26) begin
          push_item(ACT_PATTERN, pick_symbol(base, span));
          done++;
        end else if (k < 27) begin
          // broken sequence: the pattern is emptied; stray pattern items before the next text refill it
          push_item(ACT_CLEAR, SYM_W'($urandom));
          done++;
        end else begin
          push_item(ACT_TEXT, pick_symbol(base, span));
          emitted++;
          done++;
        end
      end
    end
  endtask

  initial begin
    rst              <= 1'b1;
    item_in.valid    <= 1'b0;
    item_in.action   <= ACT_CLEAR;
    item_in.symbol   <= '0;
    row_known        <= 1'b0;
    row_verdict      <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < DIRECTED_ROWS; r++)
      push_item(directed[r].action, directed[r].symbol, directed[r].known,
                directed[r].verdict);

    random_phase(PHASE_ITEMS);
    tx_idle_pct = 88;
    rx_idle_pct = 15;
    random_phase(PHASE_ITEMS);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_phase(PHASE_ITEMS);
    item_in.valid <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d expected results never arrived", pending_verdicts.size());
      errors++;
    end
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
